### hw/rtl/ecgrpd_pkg.sv
// Shared constants, widths and control structs for the ECG R-peak rate detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ecgrpd_pkg;

  // moving-average window
  localparam int WINDOW_LEN = 5;
  localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int HP_W     = 11;
  localparam int RATE_W   = 10;
  localparam int FRAC_W   = 16;
  localparam int DC_W     = SAMPLE_W + FRAC_W;
  localparam int TIME_W   = 32;
  localparam int TOTAL_W  = $clog2(WINDOW_LEN * (1 << SAMPLE_W)) + 1;

  // shared dc multiplier: 17-bit coefficient by 26-bit operand
  localparam int COEF_W = FRAC_W + 1;
  localparam int MUL_W  = COEF_W + DC_W;

  // divide by the window length as a multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = TOTAL_W + 4;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int LP_PROD_W   = TOTAL_W + RECIP_W;

  // heart rate
  localparam int DIV_W       = 16;
  localparam int RATE_NUM    = 60000;
  localparam int RATE_MAX    = 600;
  localparam int RATE_MIN_IV = RATE_NUM / RATE_MAX;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 10;
  localparam int COEFF_W    = 16;
  localparam int REFR_W     = 11;
  localparam int PERIOD_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_COEFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd3;

  localparam logic [THR_W-1:0]    THRESHOLD_RST  = 10'd20;
  localparam logic [COEFF_W-1:0]  DC_COEFF_RST   = 16'd65208;
  localparam logic [REFR_W-1:0]   REFRACTORY_RST = 11'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd4;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic mul_first;
    logic mul_second;
    logic dc_load;
    logic hp_load;
    logic win_load;
    logic lp_mul;
    logic det;
    logic rate_check;
    logic rate_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/ecgrpd_div.sv
// Restoring divider, one quotient bit per cycle, for the heart-rate numerator.
// Depends on ecgrpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecgrpd_div import ecgrpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic      [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   shifted;
  logic             ge;
  logic [DIV_W:0]   rem_next;

  assign shifted  = {rem, quotient[DIV_W-1]};
  assign ge       = shifted >= {1'b0, dsr};
  assign rem_next = ge ? (shifted - {1'b0, dsr}) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= DIV_W'(RATE_NUM);
    end else if (busy) begin
      rem      <= rem_next[DIV_W-1:0];
      quotient <= {quotient[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ecgrpd_dp.sv
// Datapath: config registers, dc tracking filter, moving window, beat logic, rate.
// Depends on ecgrpd_pkg and ecgrpd_div; driven by ecgrpd_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ecgrpd_dp import ecgrpd_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [CFG_IDX_W-1:0]       wr_index,
  input  wire logic [CFG_DATA_W-1:0]      wr_data,
  input  wire logic [SAMPLE_W-1:0]        sample,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  output logic signed [HP_W-1:0]          high_passed,
  output logic signed [HP_W-1:0]          smoothed,
  output logic                            beat,
  output logic        [RATE_W-1:0]        rate_bpm
);

  // configuration
  logic [THR_W-1:0]    thr;
  logic [COEFF_W-1:0]  alpha;
  logic [REFR_W-1:0]   refr;
  logic [PERIOD_W-1:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THRESHOLD_RST;
      alpha  <= DC_COEFF_RST;
      refr   <= REFRACTORY_RST;
      period <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD:  thr    <= wr_data[THR_W-1:0];
        REG_DC_COEFF:   alpha  <= wr_data[COEFF_W-1:0];
        REG_REFRACTORY: refr   <= wr_data[REFR_W-1:0];
        REG_PERIOD:     period <= wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // dc tracking
  logic [SAMPLE_W-1:0] x;
  logic [DC_W-1:0]     dc;
  logic                seeded;
  logic [COEF_W-1:0]   beta;
  logic [COEF_W-1:0]   mul_a;
  logic [DC_W-1:0]     mul_b;
  logic [MUL_W-1:0]    prod;
  logic [MUL_W-1:0]    p1;
  logic [DC_W-1:0]     p2;
  logic [DC_W:0]       dc_sum;

  assign beta   = COEF_W'(1 << FRAC_W) - {1'b0, alpha};
  assign mul_a  = cmd.mul_second ? beta : {1'b0, alpha};
  assign mul_b  = cmd.mul_second ? DC_W'(x) : dc;
  assign prod   = mul_a * mul_b;
  // low product bits drop out: the second term is a multiple of 2^16
  assign dc_sum = p1[MUL_W-1 -: DC_W+1] + {1'b0, p2};

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
      dc     <= '0;
    end else begin
      if (cmd.take) begin
        if (!seeded) begin
          dc     <= {sample, FRAC_W'(0)};
          seeded <= 1'b1;
        end
      end else if (cmd.dc_load) begin
        dc <= dc_sum[DC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x <= sample;
    end
    if (cmd.mul_first) begin
      p1 <= prod;
    end
    if (cmd.mul_second) begin
      p2 <= prod[DC_W-1:0];
    end
  end

  // high-pass value, truncated toward zero
  logic [DC_W:0]         diff;
  logic [DC_W:0]         diff_neg;
  logic [SAMPLE_W-1:0]   hp_mag;
  logic signed [HP_W-1:0] hp;

  assign diff     = {1'b0, x, FRAC_W'(0)} - {1'b0, dc};
  assign diff_neg = -diff;
  assign hp_mag   = diff[DC_W] ? diff_neg[DC_W-1 -: SAMPLE_W] : diff[DC_W-1 -: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (cmd.hp_load) begin
      hp <= diff[DC_W] ? -$signed({1'b0, hp_mag}) : $signed({1'b0, hp_mag});
    end
  end

  // moving window
  logic signed [HP_W-1:0]    store [WINDOW_LEN];
  logic        [PTR_W-1:0]   ptr;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] total_next;
  logic [TIME_W-1:0]         elapsed;

  assign total_next = total - TOTAL_W'(store[ptr]) + TOTAL_W'(hp);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        store[i] <= '0;
      end
      ptr     <= '0;
      total   <= '0;
      elapsed <= '0;
    end else if (cmd.win_load) begin
      store[ptr] <= hp;
      total      <= total_next;
      ptr        <= (ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr + 1'b1;
      elapsed    <= elapsed + TIME_W'(period);
    end
  end

  // window average
  logic [TOTAL_W-1:0]   tot_mag;
  logic [LP_PROD_W-1:0] lp_prod;
  logic                 lp_neg;
  logic [HP_W-1:0]      lp_q;

  assign tot_mag = total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
  assign lp_q    = lp_prod[RECIP_SHIFT +: HP_W];

  always_ff @(posedge clk) begin
    if (cmd.lp_mul) begin
      lp_prod <= tot_mag * RECIP_W'(RECIP);
      lp_neg  <= total[TOTAL_W-1];
    end
  end

  // beat detection with hysteresis
  logic signed [TOTAL_W-1:0] thw;
  logic signed [TOTAL_W-1:0] half_thw;
  logic [TIME_W-1:0]         since;
  logic [TIME_W-1:0]         last_beat;
  logic [TIME_W-1:0]         iv;
  logic                      have_prev;
  logic                      in_beat;
  logic                      rate_req;
  logic                      beat_r;
  logic signed [HP_W-1:0]    lp;

  assign thw      = TOTAL_W'(thr * WINDOW_LEN);
  assign half_thw = TOTAL_W'((thr >> 1) * WINDOW_LEN);
  assign since    = elapsed - last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_beat <= '0;
      have_prev <= 1'b0;
      in_beat   <= 1'b0;
      rate_req  <= 1'b0;
      beat_r    <= 1'b0;
    end else if (cmd.det) begin
      beat_r   <= 1'b0;
      rate_req <= 1'b0;
      if (total > thw && since > TIME_W'(refr)) begin
        if (!in_beat) begin
          in_beat   <= 1'b1;
          beat_r    <= 1'b1;
          rate_req  <= have_prev;
          have_prev <= 1'b1;
          last_beat <= elapsed;
        end
      end else if (total < half_thw) begin
        in_beat <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.det) begin
      iv <= since;
      lp <= lp_neg ? -$signed(lp_q) : $signed(lp_q);
    end
  end

  // heart rate: saturate short intervals, zero long ones, divide the rest
  logic             div_needed;
  logic             div_busy;
  logic [DIV_W-1:0] quotient;
  logic [RATE_W-1:0] rate;

  assign div_needed = rate_req && iv >= TIME_W'(RATE_MIN_IV) && iv <= TIME_W'(RATE_NUM);

  ecgrpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.rate_check && div_needed),
    .divisor  (iv[DIV_W-1:0]),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= '0;
    end else if (cmd.rate_check && rate_req) begin
      if (iv < TIME_W'(RATE_MIN_IV)) begin
        rate <= RATE_W'(RATE_MAX);
      end else if (iv > TIME_W'(RATE_NUM)) begin
        rate <= '0;
      end
    end else if (cmd.rate_load) begin
      rate <= quotient[RATE_W-1:0];
    end
  end

  assign status.div_needed = div_needed;
  assign status.div_busy   = div_busy;

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      high_passed <= hp;
      smoothed    <= lp;
      beat        <= beat_r;
      rate_bpm    <= rate;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ecgrpd_ctrl.sv
// Controller: sequences one sample through the datapath and owns both handshakes.
// Depends on ecgrpd_pkg; drives ecgrpd_dp through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ecgrpd_ctrl import ecgrpd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_DC   = 4'd3;
  localparam logic [3:0] S_HP   = 4'd4;
  localparam logic [3:0] S_WIN  = 4'd5;
  localparam logic [3:0] S_LP   = 4'd6;
  localparam logic [3:0] S_DET  = 4'd7;
  localparam logic [3:0] S_RATE = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_first = 1'b1;
        state_next    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_second = 1'b1;
        state_next     = S_DC;
      end
      S_DC: begin
        cmd.dc_load = 1'b1;
        state_next  = S_HP;
      end
      S_HP: begin
        cmd.hp_load = 1'b1;
        state_next  = S_WIN;
      end
      S_WIN: begin
        cmd.win_load = 1'b1;
        state_next   = S_LP;
      end
      S_LP: begin
        cmd.lp_mul = 1'b1;
        state_next = S_DET;
      end
      S_DET: begin
        cmd.det    = 1'b1;
        state_next = S_RATE;
      end
      S_RATE: begin
        cmd.rate_check = 1'b1;
        state_next     = status.div_needed ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          cmd.rate_load = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ecg_r_peak_rate_detector.sv
// ECG R-peak detector with heart rate: one 10-bit sample in, one result word out.
// A sample is taken while in_stall is low and goes through the states MUL1, MUL2,
// DC, HP, WIN, LP, DET, RATE, then DIV when a beat interval of 100 to 60000 ms needs
// the 16-step restoring divider, and OUT, which waits while the held word stalls. The
// next sample is taken back in IDLE. The output register holds a finished word while
// the next sample is already being worked on. Registers are to be written through
// wr_en / wr_index / wr_data while no word is pending; the block does not enforce it.
// Depends on ecgrpd_pkg, ecgrpd_ctrl and ecgrpd_dp.
`timescale 1ns / 1ps
`default_nettype none

module ecg_r_peak_rate_detector import ecgrpd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [CFG_IDX_W-1:0]    wr_index,
  input  wire logic [CFG_DATA_W-1:0]   wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SAMPLE_W-1:0]     sample,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [HP_W-1:0]       high_passed,
  output logic signed [HP_W-1:0]       smoothed,
  output logic                         beat,
  output logic        [RATE_W-1:0]     rate_bpm
);

  cmd_t    cmd;
  status_t status;

  ecgrpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ecgrpd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .sample      (sample),
    .cmd         (cmd),
    .status      (status),
    .high_passed (high_passed),
    .smoothed    (smoothed),
    .beat        (beat),
    .rate_bpm    (rate_bpm)
  );

endmodule

`default_nettype wire

### hw/rtl/ecgrpd_chk.sv
// Port-level checks for the ECG R-peak rate detector, bound to the top level.
// Depends on ecgrpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecgrpd_chk import ecgrpd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [HP_W-1:0]       high_passed,
  input wire logic [HP_W-1:0]       smoothed,
  input wire logic                  beat,
  input wire logic [RATE_W-1:0]     rate_bpm
);

  // one sample at a time: taking a word closes the input for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(high_passed) && $stable(smoothed)
      && $stable(beat) && $stable(rate_bpm))
    else $error("stalled output word changed");

  a_rate_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rate_bpm <= RATE_W'(RATE_MAX))
    else $error("rate above saturation");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> high_passed != {1'b1, (HP_W-1)'(0)} && smoothed != {1'b1, (HP_W-1)'(0)})
    else $error("filtered value out of range");

endmodule

bind ecg_r_peak_rate_detector ecgrpd_chk u_chk (.*);

`default_nettype wire

### sim/tb_ecg_r_peak_rate_detector.sv
`timescale 1ns / 1ps
// Testbench for ecg_r_peak_rate_detector: a directed table, then random beat trains
// under several register settings, each word checked against a behavioral model or its table entry.
// Depends on ecgrpd_pkg and the block's RTL.

module tb_ecg_r_peak_rate_detector;
  import ecgrpd_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 15;

  typedef struct packed {
    logic signed [HP_W-1:0] hp;
    logic signed [HP_W-1:0] lp;
    logic                   beat;
    logic [RATE_W-1:0]      rate;
  } ecg_word_t;

  typedef struct packed {
    logic                retune;
    logic [SAMPLE_W-1:0] level;
    logic                typed;
    ecg_word_t           want;
  } directed_row_t;

  typedef struct packed {
    int unsigned thr;
    int unsigned coeff;
    int unsigned refr;
    int unsigned period;
    int unsigned count;
    int unsigned quiet_lo;
    int unsigned quiet_hi;
    int unsigned noise_pct;
    logic        steady;
  } beat_phase_t;

  localparam ecg_word_t ZERO_WORD = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [HP_W-1:0] high_passed;
  logic signed [HP_W-1:0] smoothed;
  logic                  beat;
  logic [RATE_W-1:0]     rate_bpm;

  ecg_r_peak_rate_detector dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .high_passed(high_passed), .smoothed(smoothed), .beat(beat), .rate_bpm(rate_bpm)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model registers and state
  logic [THR_W-1:0]    thr_reg    = THRESHOLD_RST;
  logic [COEFF_W-1:0]  coeff_reg  = DC_COEFF_RST;
  logic [REFR_W-1:0]   refr_reg   = REFRACTORY_RST;
  logic [PERIOD_W-1:0] period_reg = PERIOD_RST;
  logic [DC_W-1:0]     dc_est = '0;
  bit                  dc_seeded = 1'b0;
  int                  win_taps [WINDOW_LEN];
  int                  win_ptr = 0;
  int                  win_sum = 0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic [TIME_W-1:0]   last_beat_at = '0;
  bit                  had_beat = 1'b0;
  bit                  beat_active = 1'b0;
  logic [RATE_W-1:0]   bpm_now = '0;

  ecg_word_t     pending_words [$];
  int            mismatches = 0;
  bit            steady = 1'b0;
  int            quiet_cycles = 0;
  directed_row_t directed_rows [25];
  beat_phase_t   beat_phases [5];

  initial foreach (win_taps[i]) win_taps[i] = 0;

  function automatic ecg_word_t next_ecg_word(input logic [SAMPLE_W-1:0] s);
    longint unsigned xq;
    longint unsigned alpha;
    longint unsigned mixed;
    longint          delta;
    int              hp;
    int              lp;
    int unsigned     bpm;
    logic [TIME_W-1:0] gap;
    ecg_word_t       w;
    xq = longint'(s) << FRAC_W;
    alpha = longint'(coeff_reg);
    if (!dc_seeded) begin
      dc_est = xq[DC_W-1:0];
      dc_seeded = 1'b1;
    end
    mixed = (alpha * dc_est + ((longint'(1) << FRAC_W) - alpha) * xq) >> FRAC_W;
    dc_est = mixed[DC_W-1:0];
    delta = longint'(xq) - longint'(dc_est);
    // truncate toward zero on both sides
    hp = (delta >= 0) ? int'(delta >>> FRAC_W) : -int'((-delta) >>> FRAC_W);
    win_sum = win_sum - win_taps[win_ptr] + hp;
    win_taps[win_ptr] = hp;
    win_ptr = (win_ptr == WINDOW_LEN - 1) ? 0 : win_ptr + 1;
    lp = win_sum / WINDOW_LEN;
    now_ms = now_ms + period_reg;
    gap = now_ms - last_beat_at;
    w.beat = 1'b0;
    if (win_sum > int'(thr_reg) * WINDOW_LEN && gap > refr_reg) begin
      // held over threshold leaves the beat state alone
      if (!beat_active) begin
        beat_active = 1'b1;
        w.beat = 1'b1;
        if (had_beat) begin
          bpm = (gap == 0) ? RATE_MAX : RATE_NUM / gap;
          bpm_now = RATE_W'((bpm > RATE_MAX) ? RATE_MAX : bpm);
        end
        had_beat = 1'b1;
        last_beat_at = now_ms;
      end
    end else if (win_sum < (int'(thr_reg) / 2) * WINDOW_LEN) begin
      beat_active = 1'b0;
    end
    w.hp = hp[HP_W-1:0];
    w.lp = lp[HP_W-1:0];
    w.rate = bpm_now;
    return w;
  endfunction

  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic typed,
                           input ecg_word_t want);
    ecg_word_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_ecg_word(s);
    pending_words.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_THRESHOLD:  thr_reg = value[THR_W-1:0];
      REG_DC_COEFF:   coeff_reg = value[COEFF_W-1:0];
      REG_REFRACTORY: refr_reg = value[REFR_W-1:0];
      REG_PERIOD:     period_reg = value[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // registers change only once every word is out and the pipe has gone quiet
  task automatic apply_setting(input int unsigned thr, input int unsigned coeff,
                               input int unsigned refr, input int unsigned period);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_DC_COEFF, coeff);
    write_reg(REG_REFRACTORY, refr);
    write_reg(REG_PERIOD, period);
  endtask

  // baseline with jitter, a peak, a short dip after it; some words are pure noise
  task automatic run_heartbeats(input int count, input int quiet_lo, input int quiet_hi,
                                input int noise_pct);
    int sent;
    int quiet;
    int width;
    int amp;
    int base;
    int v;
    bit first;
    sent = 0;
    first = 1'b1;
    base = $urandom_range(150, 850);
    while (sent < count) begin
      quiet = first ? $urandom_range(8, 12) : $urandom_range(quiet_lo, quiet_hi);
      first = 1'b0;
      width = $urandom_range(1, 4);
      amp = $urandom_range(80, 400);
      for (int k = 0; k < quiet + width + 2 && sent < count; k++) begin
        if ($urandom_range(0, 99) < noise_pct) v = $urandom_range(0, 1023);
        else if (k < quiet) v = base + int'($urandom_range(0, 6)) - 3;
        else if (k < quiet + width) v = base + amp;
        else v = base - int'($urandom_range(0, amp / 2));
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        send_word(v[SAMPLE_W-1:0], 1'b0, ZERO_WORD);
        sent++;
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

  always @(posedge clk) begin : word_check
    ecg_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual hp=%0d lp=%0d beat=%0d bpm=%0d",
                 $time, high_passed, smoothed, beat, rate_bpm);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        check_field("high_passed", w.hp, high_passed);
        check_field("smoothed", w.lp, smoothed);
        check_field("beat", w.beat, beat);
        check_field("rate_bpm", w.rate, rate_bpm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    directed_rows = '{
      '{1'b0, 10'd0,    1'b1, ZERO_WORD},  // first word seeds the dc estimate
      '{1'b0, 10'd0,    1'b1, ZERO_WORD},
      '{1'b0, 10'd1023, 1'b1, '{11'sd1017, 11'sd203, 1'b0, 10'd0}},  // full-scale step
      '{1'b0, 10'd1023, 1'b0, ZERO_WORD},  // over threshold inside refractory time
      '{1'b0, 10'd1023, 1'b0, ZERO_WORD},
      '{1'b0, 10'd1023, 1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b1, 10'd0,    1'b0, ZERO_WORD},  // fast time base from here on
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd600,  1'b0, ZERO_WORD},
      '{1'b0, 10'd600,  1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd600,  1'b0, ZERO_WORD},
      '{1'b0, 10'd600,  1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd0,    1'b0, ZERO_WORD},
      '{1'b0, 10'd1023, 1'b0, ZERO_WORD},
      '{1'b0, 10'd1023, 1'b0, ZERO_WORD}
    };
    // last phase has intervals past 60000 ms, so the rate drops to zero
    beat_phases = '{
      '{20,   65208, 250,  4,   50,  40,  70,  10, 1'b0},
      '{0,    65535, 100,  255, 40,  0,   6,   10, 1'b1},
      '{1023, 0,     2000, 1,   25,  0,   10,  20, 1'b0},
      '{50,   60000, 300,  25,  30,  8,   20,  10, 1'b1},
      '{10,   40000, 2000, 255, 260, 236, 240, 0,  1'b0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].retune) apply_setting(20, 32768, 100, 200);
      send_word(directed_rows[i].level, directed_rows[i].typed, directed_rows[i].want);
    end
    foreach (beat_phases[i]) begin
      apply_setting(beat_phases[i].thr, beat_phases[i].coeff, beat_phases[i].refr,
                    beat_phases[i].period);
      steady = beat_phases[i].steady;
      run_heartbeats(beat_phases[i].count, beat_phases[i].quiet_lo, beat_phases[i].quiet_hi,
                     beat_phases[i].noise_pct);
      steady = 1'b0;
    end
    repeat (2) begin
      apply_setting($urandom_range(0, 120), $urandom_range(0, 65535),
                    $urandom_range(100, 2000), $urandom_range(1, 255));
      run_heartbeats(10, 2, 30, 10);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
